// ===== rtl/mx4p_pkg.sv =====
// shared types and codes for the 4x4 matrix product block
package mx4p_pkg;

	localparam int MX4P_DIM    = 4;
	localparam int MX4P_WORD_W = 32;
	localparam int MX4P_PROD_W = 2 * MX4P_WORD_W;
	localparam int MX4P_SUM_W  = MX4P_PROD_W + 2;

	typedef logic signed [MX4P_WORD_W-1:0] mx4p_word_t;
	typedef logic signed [MX4P_SUM_W-1:0]  mx4p_sum_t;

	typedef logic [1:0] mx4p_mode_t;
	localparam mx4p_mode_t MODE_LOAD   = 2'd0;
	localparam mx4p_mode_t MODE_FULL   = 2'd1;
	localparam mx4p_mode_t MODE_AFFINE = 2'd2;

	localparam logic [1:0] ROW_TRANSLATE = 2'd3;

	// per-lane stage enables
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} mx4p_lane_ctl_t;

	// request info carried alongside the lane data
	typedef struct packed {
		logic [1:0] row;
		logic       affine;
	} mx4p_meta_t;

endpackage

// ===== rtl/mx4p_lane.sv =====
// one output column: four multipliers then a rounded sum
module mx4p_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  mx4p_pkg::mx4p_lane_ctl_t ctl,
	input  mx4p_pkg::mx4p_word_t   a_row [mx4p_pkg::MX4P_DIM],
	input  mx4p_pkg::mx4p_word_t   b_col [mx4p_pkg::MX4P_DIM],
	output mx4p_pkg::mx4p_sum_t    sum_s2
);
	import mx4p_pkg::*;

	localparam mx4p_sum_t RND = mx4p_sum_t'(1) <<< (FRAC_BITS - 1);

	logic signed [MX4P_PROD_W-1:0] prod_s1 [MX4P_DIM];
	mx4p_sum_t sum_c;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int k = 0; k < MX4P_DIM; k++) begin
				prod_s1[k] <= MX4P_PROD_W'(a_row[k]) * MX4P_PROD_W'(b_col[k]);
			end
		end
	end

	always_comb begin
		sum_c = RND;
		for (int k = 0; k < MX4P_DIM; k++) begin
			sum_c = sum_c + MX4P_SUM_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sum_s2 <= sum_c;
		end
	end

endmodule

// ===== rtl/mx4p_merge.sv =====
// scales and clips the lane sums and holds the result register
module mx4p_merge #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 v_in,
	input  mx4p_pkg::mx4p_meta_t meta_s2,
	input  mx4p_pkg::mx4p_sum_t  sum_s2 [mx4p_pkg::MX4P_DIM],
	output logic                 out_valid,
	output logic [1:0]           out_row,
	output mx4p_pkg::mx4p_word_t res_x,
	output mx4p_pkg::mx4p_word_t res_y,
	output mx4p_pkg::mx4p_word_t res_z,
	output mx4p_pkg::mx4p_word_t res_w,
	output logic                 saturated
);
	import mx4p_pkg::*;

	localparam mx4p_word_t ONE     = mx4p_word_t'(1) <<< FRAC_BITS;
	localparam mx4p_word_t MAX_VAL = {1'b0, {(MX4P_WORD_W-1){1'b1}}};
	localparam mx4p_word_t MIN_VAL = {1'b1, {(MX4P_WORD_W-1){1'b0}}};

	mx4p_sum_t  shifted [MX4P_DIM];
	mx4p_word_t clip    [MX4P_DIM];
	logic       ovf     [MX4P_DIM];
	mx4p_word_t w_c;
	logic       sat_c;

	always_comb begin
		for (int c = 0; c < MX4P_DIM; c++) begin
			shifted[c] = sum_s2[c] >>> FRAC_BITS;
			ovf[c] = !((&shifted[c][MX4P_SUM_W-1:MX4P_WORD_W-1]) ||
				!(|shifted[c][MX4P_SUM_W-1:MX4P_WORD_W-1]));
			if (!ovf[c]) begin
				clip[c] = shifted[c][MX4P_WORD_W-1:0];
			end else if (shifted[c][MX4P_SUM_W-1]) begin
				clip[c] = MIN_VAL;
			end else begin
				clip[c] = MAX_VAL;
			end
		end
		// affine w is a constant and never clips
		sat_c = ovf[0] || ovf[1] || ovf[2];
		if (meta_s2.affine) begin
			w_c = (meta_s2.row == ROW_TRANSLATE) ? ONE : '0;
		end else begin
			w_c   = clip[3];
			sat_c = sat_c || ovf[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load && v_in) begin
			out_row   <= meta_s2.row;
			res_x     <= clip[0];
			res_y     <= clip[1];
			res_z     <= clip[2];
			res_w     <= w_c;
			saturated <= sat_c;
		end
	end

endmodule

// ===== rtl/matrix4_product_with_affine_mode.sv =====
// top level of the row-by-row 4x4 matrix product in signed fixed point
//
// usage
//   input channel: in_valid / in_stall with mode, row_index, elem_x..elem_w
//   output channel: out_valid / out_stall with out_row, res_x..res_w, saturated
//   a load request (mode 0) writes row row_index of the right-hand matrix B
//   and gives no result; a full (mode 1) or affine (mode 2) request carries one
//   row of A and gives one result row of A*B; mode 3 is dropped silently
//   a product request passes the multiply stage, the sum stage and the output
//   register in that order
//   throughput: one request per cycle while in_stall is low, loads and products
//   mixed freely; the products use sixteen multipliers (four lanes of four)
//   a load takes effect for every product request accepted after it
//   reset: B becomes the identity matrix, the pipeline empties
//   when the receiver stalls the output holds, the two inner stages fill, and
//   in_stall rises once all three stages hold a request
module matrix4_product_with_affine_mode #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [1:0]           row_index,
	input  mx4p_pkg::mx4p_word_t elem_x,
	input  mx4p_pkg::mx4p_word_t elem_y,
	input  mx4p_pkg::mx4p_word_t elem_z,
	input  mx4p_pkg::mx4p_word_t elem_w,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_row,
	output mx4p_pkg::mx4p_word_t res_x,
	output mx4p_pkg::mx4p_word_t res_y,
	output mx4p_pkg::mx4p_word_t res_z,
	output mx4p_pkg::mx4p_word_t res_w,
	output logic                 saturated
);
	import mx4p_pkg::*;

	localparam mx4p_word_t ONE = mx4p_word_t'(1) <<< FRAC_BITS;

	// right-hand matrix, b_q[row][col]
	mx4p_word_t b_q [MX4P_DIM][MX4P_DIM];

	mx4p_word_t a_eff [MX4P_DIM];
	mx4p_word_t in_elem [MX4P_DIM];

	logic       v_s1, v_s2;
	mx4p_meta_t meta_s1, meta_s2;
	mx4p_meta_t meta_in;
	logic       rdy_o, rdy_2, rdy_1;
	logic       accept, is_load, is_prod;
	mx4p_lane_ctl_t lane_ctl;
	mx4p_sum_t  sum_s2 [MX4P_DIM];

	// ready chain from the output register back to the input
	assign rdy_o    = !out_valid || !out_stall;
	assign rdy_2    = !v_s2 || rdy_o;
	assign rdy_1    = !v_s1 || rdy_2;
	assign in_stall = !rdy_1;

	assign accept  = in_valid && !in_stall;
	assign is_load = (mode == MODE_LOAD);
	assign is_prod = (mode == MODE_FULL) || (mode == MODE_AFFINE);

	assign lane_ctl.en_s1 = accept && is_prod;
	assign lane_ctl.en_s2 = rdy_2 && v_s1;

	assign meta_in.row    = row_index;
	assign meta_in.affine = (mode == MODE_AFFINE);

	assign in_elem[0] = elem_x;
	assign in_elem[1] = elem_y;
	assign in_elem[2] = elem_z;
	assign in_elem[3] = elem_w;

	// affine mode: the fourth A term becomes 1.0 on the translation row, 0 otherwise,
	// which adds B's translation row scaled by one exactly
	always_comb begin
		for (int k = 0; k < MX4P_DIM - 1; k++) begin
			a_eff[k] = in_elem[k];
		end
		if (mode == MODE_AFFINE) begin
			a_eff[MX4P_DIM-1] = (row_index == ROW_TRANSLATE) ? ONE : '0;
		end else begin
			a_eff[MX4P_DIM-1] = elem_w;
		end
	end

	// B store, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MX4P_DIM; r++) begin
				for (int c = 0; c < MX4P_DIM; c++) begin
					b_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (accept && is_load) begin
			for (int c = 0; c < MX4P_DIM; c++) begin
				b_q[row_index][c] <= in_elem[c];
			end
		end
	end

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_1) begin
				v_s1 <= in_valid && is_prod;
			end
			if (rdy_2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// request info follows the lane data
	always_ff @(posedge clk) begin
		if (lane_ctl.en_s1) begin
			meta_s1 <= meta_in;
		end
		if (lane_ctl.en_s2) begin
			meta_s2 <= meta_s1;
		end
	end

	// one lane per output column
	for (genvar c = 0; c < MX4P_DIM; c++) begin : g_lane
		mx4p_word_t b_col [MX4P_DIM];

		for (genvar k = 0; k < MX4P_DIM; k++) begin : g_col
			assign b_col[k] = b_q[k][c];
		end

		mx4p_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.ctl   (lane_ctl),
			.a_row (a_eff),
			.b_col (b_col),
			.sum_s2(sum_s2[c])
		);
	end

	// clip, affine w and the output register
	mx4p_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rdy_o),
		.v_in     (v_s2),
		.meta_s2  (meta_s2),
		.sum_s2   (sum_s2),
		.out_valid(out_valid),
		.out_row  (out_row),
		.res_x    (res_x),
		.res_y    (res_y),
		.res_z    (res_z),
		.res_w    (res_w),
		.saturated(saturated)
	);

	// input only stalls when every stage holds a request
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid))
		else $error("input stalled with a free pipeline stage");

	// an accepted product request always occupies the first stage
	a_prod_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (mode == MODE_FULL || mode == MODE_AFFINE)) |=> v_s1)
		else $error("product request lost at entry");

	// a load lands in the store on the next cycle
	a_load_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_LOAD) |=>
		(b_q[$past(row_index)][0] == $past(elem_x)))
		else $error("load request not written to the store");

endmodule

// ===== tb/mx4p_product_checker.sv =====
// checker for the 4x4 matrix product block: tracks B, predicts result rows and compares them
`timescale 1ns / 100ps
module mx4p_product_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [1:0]           row_index,
	input  mx4p_pkg::mx4p_word_t elem_x,
	input  mx4p_pkg::mx4p_word_t elem_y,
	input  mx4p_pkg::mx4p_word_t elem_z,
	input  mx4p_pkg::mx4p_word_t elem_w,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           out_row,
	input  mx4p_pkg::mx4p_word_t res_x,
	input  mx4p_pkg::mx4p_word_t res_y,
	input  mx4p_pkg::mx4p_word_t res_z,
	input  mx4p_pkg::mx4p_word_t res_w,
	input  logic                 saturated,
	output int                   err_count,
	output int                   rows_pending
);
	import mx4p_pkg::*;

	typedef struct packed {
		logic [1:0] row;
		mx4p_word_t x;
		mx4p_word_t y;
		mx4p_word_t z;
		mx4p_word_t w;
		logic       clip;
	} product_row_t;

	mx4p_word_t   b_store [MX4P_DIM*MX4P_DIM];
	product_row_t product_rows_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t checker: %s", $time, msg);
		err_count++;
	endtask

	// round half up, then clip to the signed 32-bit range
	function automatic logic round_clip(input logic signed [79:0] acc, output mx4p_word_t val);
		logic signed [79:0] v;
		v = (acc + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (&v[79:31] || !(|v[79:31])) begin
			val = v[31:0];
			return 1'b0;
		end
		val = v[79] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return 1'b1;
	endfunction

	function automatic product_row_t compute_product_row(input logic affine, input logic [1:0] row,
			input mx4p_word_t a0, input mx4p_word_t a1, input mx4p_word_t a2, input mx4p_word_t a3);
		mx4p_word_t         a [4];
		mx4p_word_t         res [4];
		mx4p_word_t         val;
		logic signed [79:0] acc;
		logic signed [79:0] lhs;
		logic signed [79:0] rhs;
		logic               any_clip;
		int                 terms;
		product_row_t       p;
		a[0] = a0;
		a[1] = a1;
		a[2] = a2;
		a[3] = a3;
		any_clip = 1'b0;
		terms = affine ? 3 : MX4P_DIM;
		for (int c = 0; c < MX4P_DIM; c++) begin
			if (affine && c == MX4P_DIM - 1) begin
				res[c] = (row == ROW_TRANSLATE) ? (32'sd1 <<< FRAC_BITS) : '0;
			end else begin
				acc = '0;
				for (int k = 0; k < terms; k++) begin
					lhs = a[k];
					rhs = b_store[k*MX4P_DIM + c];
					acc = acc + lhs * rhs;
				end
				if (affine && row == ROW_TRANSLATE) begin
					rhs = b_store[ROW_TRANSLATE*MX4P_DIM + c];
					acc = acc + (rhs <<< FRAC_BITS);
				end
				if (round_clip(acc, val))
					any_clip = 1'b1;
				res[c] = val;
			end
		end
		p.row  = row;
		p.x    = res[0];
		p.y    = res[1];
		p.z    = res[2];
		p.w    = res[3];
		p.clip = any_clip;
		return p;
	endfunction

	task automatic compare_word(input string name, input mx4p_word_t got, input mx4p_word_t want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_result_row();
		product_row_t want;
		if (product_rows_q.size() == 0) begin
			report_mismatch($sformatf("result row %0d with nothing expected", out_row));
			return;
		end
		want = product_rows_q.pop_front();
		if (out_row !== want.row)
			report_mismatch($sformatf("out_row got %0d want %0d", out_row, want.row));
		compare_word("res_x", res_x, want.x);
		compare_word("res_y", res_y, want.y);
		compare_word("res_z", res_z, want.z);
		compare_word("res_w", res_w, want.w);
		if (saturated !== want.clip)
			report_mismatch($sformatf("saturated got %b want %b", saturated, want.clip));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MX4P_DIM*MX4P_DIM; i++)
				b_store[i] = (i / MX4P_DIM == i % MX4P_DIM) ? (32'sd1 <<< FRAC_BITS) : '0;
			product_rows_q.delete();
			rows_pending = 0;
			err_count = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result_row();
			if (in_valid && !in_stall) begin
				if (mode == MODE_LOAD) begin
					b_store[row_index*MX4P_DIM + 0] = elem_x;
					b_store[row_index*MX4P_DIM + 1] = elem_y;
					b_store[row_index*MX4P_DIM + 2] = elem_z;
					b_store[row_index*MX4P_DIM + 3] = elem_w;
				end else if (mode == MODE_FULL || mode == MODE_AFFINE) begin
					product_rows_q.push_back(compute_product_row(mode == MODE_AFFINE, row_index,
						elem_x, elem_y, elem_z, elem_w));
				end
			end
			rows_pending = product_rows_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the 4x4 matrix product testbench: clock, reset, requests, stalls and verdict
`timescale 1ns / 100ps
module tb_top;
	import mx4p_pkg::*;

	localparam int         FRAC_BITS       = 16;
	localparam mx4p_mode_t MODE_UNUSED     = 2'd3;    // dropped by the block
	localparam int         RANDOM_REQUESTS = 400;
	localparam int         DRAIN_CYCLES    = 8;
	localparam int         CYCLE_LIMIT     = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] mode;
	logic [1:0] row_index;
	mx4p_word_t elem_x;
	mx4p_word_t elem_y;
	mx4p_word_t elem_z;
	mx4p_word_t elem_w;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] out_row;
	mx4p_word_t res_x;
	mx4p_word_t res_y;
	mx4p_word_t res_z;
	mx4p_word_t res_w;
	logic       saturated;
	int         err_count;
	int         rows_pending;
	bit         gaps_on;
	int         cycle_count;

	matrix4_product_with_affine_mode #(.FRAC_BITS(FRAC_BITS)) uut (.*);

	// watches both channels, predicts every product row and counts mismatches
	mx4p_product_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver side: random stalls while gaps are enabled
	always @(posedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 11);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// element values: extremes, full random words, and small values around +-4.0
	// so that most products stay inside the range and rounding is exercised
	function automatic mx4p_word_t pick_elem();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return $urandom_range(32'h8_0000) - 32'h4_0000;
		endcase
	endfunction

	// one request: optional idle cycles, then hold the payload until accepted;
	// valid stays high from one request to the next when no gap is taken
	task automatic send_request(input mx4p_mode_t m, input logic [1:0] r,
			input mx4p_word_t x, input mx4p_word_t y, input mx4p_word_t z, input mx4p_word_t w);
		while (gaps_on && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		row_index <= r;
		elem_x    <= x;
		elem_y    <= y;
		elem_z    <= z;
		elem_w    <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// sender holds off until every predicted row has come out
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (rows_pending != 0);
		@(posedge clk);
	endtask

	// random mix of loads, full rows and affine rows; ignored requests do not count
	task automatic run_random(input int n);
		int         sent;
		int         pick;
		mx4p_mode_t m;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 20)
				m = MODE_LOAD;
			else if (pick < 58)
				m = MODE_FULL;
			else if (pick < 96)
				m = MODE_AFFINE;
			else
				m = MODE_UNUSED;
			send_request(m, 2'($urandom_range(3)), pick_elem(), pick_elem(), pick_elem(),
				pick_elem());
			if (m != MODE_UNUSED)
				sent++;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = MODE_LOAD;
		row_index   = '0;
		elem_x      = '0;
		elem_y      = '0;
		elem_z      = '0;
		elem_w      = '0;
		gaps_on     = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// B still identity after reset: rows pass through unchanged
		send_request(MODE_FULL, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		// affine translate row with zero translation gives w = 1.0
		send_request(MODE_AFFINE, ROW_TRANSLATE, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			32'h0000_7FFF);
		// affine plain row gives w = 0
		send_request(MODE_AFFINE, 2'd1, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h1234_5678);
		// unused mode: no result, no load
		send_request(MODE_UNUSED, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// extreme B rows to force clipping in both directions
		send_request(MODE_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(MODE_LOAD, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_request(MODE_LOAD, ROW_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
			32'hFFFF_8000);
		send_request(MODE_FULL, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_request(MODE_FULL, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_request(MODE_AFFINE, ROW_TRANSLATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
			32'h0000_0000);
		// zero row of A on the translate row returns the translation itself
		send_request(MODE_AFFINE, ROW_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000);
		send_request(MODE_AFFINE, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

		// exact half-way products round toward plus infinity
		send_request(MODE_LOAD, 2'd2, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_request(MODE_FULL, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		send_request(MODE_FULL, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		// unused mode carrying a load-like payload must leave row 2 alone
		send_request(MODE_UNUSED, 2'd2, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
		send_request(MODE_FULL, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		// affine row ignores elem_w
		send_request(MODE_AFFINE, 2'd2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h7FFF_FFFF);

		run_random(RANDOM_REQUESTS * 3 / 8);
		// back-off: let the pipeline empty completely before going on
		wait_for_drain();
		// a stretch at full rate on both sides
		gaps_on <= 1'b0;
		run_random(RANDOM_REQUESTS / 4);
		gaps_on <= 1'b1;
		run_random(RANDOM_REQUESTS - RANDOM_REQUESTS * 3 / 8 - RANDOM_REQUESTS / 4);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
